// ===== src/rau_pkg.sv =====
// shared types and constants for the rational arithmetic unit
package rau_pkg;

    localparam int unsigned CMD_W = 3;
    localparam int unsigned FLD_W = 16;
    localparam int unsigned IN_TDATA_W = 72;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned NUM_W = 32;
    localparam int unsigned DEN_W = 31;
    // wide enough for any sum of two 64-bit products
    localparam int unsigned XW = 66;

    typedef logic [CMD_W-1:0] t_cmd;

    localparam t_cmd CMD_ADD = 3'd0;
    localparam t_cmd CMD_SUB = 3'd1;
    localparam t_cmd CMD_MUL = 3'd2;
    localparam t_cmd CMD_DIV = 3'd3;
    localparam t_cmd CMD_LT  = 3'd4;
    localparam t_cmd CMD_GT  = 3'd5;

    localparam logic signed [XW-1:0] NUM_MAX = XW'(64'sd2147483647);
    localparam logic signed [XW-1:0] NUM_MIN = -XW'(64'sd2147483648);
    localparam logic [XW-1:0] DEN_MAX = XW'(64'd2147483647);

endpackage

// ===== src/rau_gcd.sv =====
// iterative binary gcd, one shift or subtract step per cycle
module rau_gcd #(
    parameter int unsigned GW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [GW-1:0] i_x,
    input  logic [GW-1:0] i_y,
    output logic          o_done,
    output logic [GW-1:0] o_gcd
);
    localparam int unsigned KW = $clog2(GW + 1);

    logic          r_busy;
    logic          r_done;
    logic [GW-1:0] r_x;
    logic [GW-1:0] r_y;
    logic [KW-1:0] r_k;
    logic [GW-1:0] r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_x    <= i_x;
                r_y    <= i_y;
                r_k    <= '0;
            end else if (r_busy) begin
                if (r_x == '0) begin
                    r_res  <= r_y << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_y == '0) begin
                    r_res  <= r_x << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x >= r_y) begin
                    r_x <= r_x - r_y;
                end else begin
                    r_y <= r_y - r_x;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_res;

endmodule

// ===== src/rau_div.sv =====
// restoring divider, one quotient bit per cycle
module rau_div #(
    parameter int unsigned DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    localparam int unsigned CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;

    assign w_shift = {r_rem[DW-1:0], r_quo[DW-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                if (!w_diff[DW]) begin
                    r_rem <= w_diff;
                    r_quo <= {r_quo[DW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_quo <= {r_quo[DW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== src/rational_arithmetic_unit.sv =====
// rational arithmetic unit: sequencer, shared multiplier, gcd and divider
//
//  channel   | direction | tdata fields (low bit up)
//  s_axis    | in        | cmd[2:0] a_num[18:3] a_den[34:19] b_num[50:35] b_den[66:51]
//  m_axis    | out       | res_num[31:0] res_den[62:32] cmp_true[63] zero_den_error[64]
//
// one transfer in at a time; o_s_axis_tready is high only while the sequencer is idle
// add/sub: gcd of the two denominators, two divides, then three multiplies
// mul/div: two multiplies, then a gcd over 2W bits and two divides
// compares run two multiplies and finish; operand errors and unused codes go straight to the finish state
// the result waits in the output register while m_axis stalls; reset is synchronous, low
module rational_arithmetic_unit #(
    parameter int unsigned OPERAND_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // cmd, a_num, a_den, b_num, b_den
    input  logic [rau_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // res_num, res_den, cmp_true, zero_den_error
    output logic [rau_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    localparam int unsigned W  = OPERAND_WIDTH;
    localparam int unsigned PW = 2 * W;
    localparam int unsigned XW = rau_pkg::XW;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]          r_state;
    rau_pkg::t_cmd       r_cmd;
    logic                r_phase;
    logic                r_dsel;
    logic [1:0]          r_msel;
    logic                r_spec;
    logic                r_err;
    logic                r_gcd_go;
    logic                r_div_go;
    logic                r_sa, r_sb;
    logic [W-1:0]        r_ma, r_mb, r_da, r_db;
    logic [PW-1:0]       r_g, r_q1, r_q2, r_p1, r_p2, r_p3;
    logic                r_ovalid;
    logic [31:0]         r_onum;
    logic [30:0]         r_oden;
    logic                r_ocmp;
    logic                r_oerr;

    rau_pkg::t_cmd       w_cmd;
    logic [W-1:0]        w_an, w_ad, w_bn, w_bd;
    logic                w_accept;
    logic                w_addsub;
    logic                w_gcd_done, w_div_done;
    logic [PW-1:0]       w_gcd, w_quot;
    logic [PW-1:0]       w_gx, w_gy, w_dvd;
    logic [W-1:0]        w_ma, w_mb;
    logic [PW-1:0]       w_prod;
    logic                w_last_mul;
    logic signed [XW-1:0] w_v1, w_v2, w_sum, w_nval, w_nsat;
    logic [XW-1:0]       w_dval;
    logic [30:0]         w_dsat;
    logic                w_lt, w_gt;

    assign w_cmd = i_s_axis_tdata[2:0];
    assign w_an  = W'(i_s_axis_tdata[18:3]);
    assign w_ad  = W'(i_s_axis_tdata[34:19]);
    assign w_bn  = W'(i_s_axis_tdata[50:35]);
    assign w_bd  = W'(i_s_axis_tdata[66:51]);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_addsub = (r_cmd == rau_pkg::CMD_ADD) || (r_cmd == rau_pkg::CMD_SUB);

    // gcd and divider operand selection
    assign w_gx  = r_phase ? r_p1 : PW'(r_da);
    assign w_gy  = r_phase ? r_p2 : PW'(r_db);
    assign w_dvd = r_phase ? (r_dsel ? r_p2 : r_p1) : (r_dsel ? PW'(r_da) : PW'(r_db));

    rau_gcd #(.GW(PW)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_gcd_go),
        .i_x     (w_gx),
        .i_y     (w_gy),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    rau_div #(.DW(PW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (r_div_go),
        .i_dividend (w_dvd),
        .i_divisor  (r_g),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // shared multiplier operand selection
    always_comb begin
        w_ma = r_ma;
        w_mb = r_mb;
        case (r_cmd)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                case (r_msel)
                    2'd0:    begin w_ma = r_ma;          w_mb = r_q1[W-1:0]; end
                    2'd1:    begin w_ma = r_mb;          w_mb = r_q2[W-1:0]; end
                    default: begin w_ma = r_q2[W-1:0];   w_mb = r_db;        end
                endcase
            end
            rau_pkg::CMD_MUL: begin
                if (r_msel == 2'd0) begin
                    w_ma = r_ma; w_mb = r_mb;
                end else begin
                    w_ma = r_da; w_mb = r_db;
                end
            end
            rau_pkg::CMD_DIV: begin
                if (r_msel == 2'd0) begin
                    w_ma = r_ma; w_mb = r_db;
                end else begin
                    w_ma = r_da; w_mb = r_mb;
                end
            end
            default: begin
                if (r_msel == 2'd0) begin
                    w_ma = r_ma; w_mb = r_db;
                end else begin
                    w_ma = r_mb; w_mb = r_da;
                end
            end
        endcase
    end

    assign w_prod = PW'(w_ma) * PW'(w_mb);
    assign w_last_mul = w_addsub ? (r_msel == 2'd2) : (r_msel == 2'd1);

    // final combine, compare and saturation
    always_comb begin
        w_v1 = $signed(XW'(r_p1));
        w_v2 = $signed(XW'(r_p2));
        if (r_sa) w_v1 = -w_v1;
        if (r_sb) w_v2 = -w_v2;
        w_sum = (r_cmd == rau_pkg::CMD_SUB) ? (w_v1 - w_v2) : (w_v1 + w_v2);
        w_lt  = (w_v1 < w_v2);
        w_gt  = (w_v1 > w_v2);
        if (w_addsub) begin
            w_nval = w_sum;
            w_dval = XW'(r_p3);
        end else begin
            w_nval = $signed(XW'(r_q1));
            if (r_sa ^ r_sb) w_nval = -w_nval;
            w_dval = XW'(r_q2);
        end
        if (w_nval > rau_pkg::NUM_MAX)      w_nsat = rau_pkg::NUM_MAX;
        else if (w_nval < rau_pkg::NUM_MIN) w_nsat = rau_pkg::NUM_MIN;
        else                                w_nsat = w_nval;
        w_dsat = (w_dval > rau_pkg::DEN_MAX) ? 31'h7FFF_FFFF : w_dval[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_gcd_go <= 1'b0;
            r_div_go <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_gcd_go <= 1'b0;
            r_div_go <= 1'b0;
            // in ST_FIN the output register update below owns r_ovalid
            if (r_ovalid && i_m_axis_tready && r_state != ST_FIN) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd   <= w_cmd;
                        r_sa    <= w_an[W-1] ^ w_ad[W-1];
                        r_sb    <= w_bn[W-1] ^ w_bd[W-1];
                        r_ma    <= w_an[W-1] ? W'(-w_an) : w_an;
                        r_mb    <= w_bn[W-1] ? W'(-w_bn) : w_bn;
                        r_da    <= w_ad[W-1] ? W'(-w_ad) : w_ad;
                        r_db    <= w_bd[W-1] ? W'(-w_bd) : w_bd;
                        r_msel  <= 2'd0;
                        r_dsel  <= 1'b0;
                        r_phase <= 1'b0;
                        r_spec  <= 1'b0;
                        r_err   <= 1'b0;
                        if (w_cmd > rau_pkg::CMD_GT) begin
                            r_spec  <= 1'b1;
                            r_state <= ST_FIN;
                        end else if (w_ad == '0 || w_bd == '0 ||
                                     (w_cmd == rau_pkg::CMD_DIV && w_bn == '0)) begin
                            r_spec  <= 1'b1;
                            r_err   <= 1'b1;
                            r_state <= ST_FIN;
                        end else if (w_cmd == rau_pkg::CMD_ADD || w_cmd == rau_pkg::CMD_SUB) begin
                            r_gcd_go <= 1'b1;
                            r_state  <= ST_GCD;
                        end else begin
                            r_phase <= 1'b1;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_GCD: begin
                    if (w_gcd_done) begin
                        r_g      <= w_gcd;
                        r_dsel   <= 1'b0;
                        r_div_go <= 1'b1;
                        r_state  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        if (!r_dsel) begin
                            r_q1     <= w_quot;
                            r_dsel   <= 1'b1;
                            r_div_go <= 1'b1;
                        end else begin
                            r_q2    <= w_quot;
                            r_msel  <= 2'd0;
                            r_state <= r_phase ? ST_FIN : ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    case (r_msel)
                        2'd0:    r_p1 <= w_prod;
                        2'd1:    r_p2 <= w_prod;
                        default: r_p3 <= w_prod;
                    endcase
                    r_msel <= r_msel + 2'd1;
                    if (w_last_mul) begin
                        if (w_addsub || r_cmd == rau_pkg::CMD_LT || r_cmd == rau_pkg::CMD_GT) begin
                            r_state <= ST_FIN;
                        end else begin
                            r_gcd_go <= 1'b1;
                            r_state  <= ST_GCD;
                        end
                    end
                end
                ST_FIN: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_oerr   <= r_err;
                        if (r_spec || r_cmd == rau_pkg::CMD_LT || r_cmd == rau_pkg::CMD_GT) begin
                            r_onum <= '0;
                            r_oden <= 31'd1;
                            r_ocmp <= !r_spec && ((r_cmd == rau_pkg::CMD_LT) ? w_lt : w_gt);
                        end else begin
                            r_onum <= w_nsat[31:0];
                            r_oden <= w_dsat;
                            r_ocmp <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {7'd0, r_oerr, r_ocmp, r_oden, r_onum};

endmodule

// ===== src/rau_checker.sv =====
// port-level checks for the rational arithmetic unit, bound to the top level
module rau_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [rau_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    // a finished result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // one item at a time: no transfer in on the cycle after one was taken
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken while busy");

    // an error result is 0/1 with no compare flag
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[64] |->
            o_m_axis_tdata[31:0] == 32'd0 && o_m_axis_tdata[62:32] == 31'd1 &&
            !o_m_axis_tdata[63])
        else $error("bad error result");

    // a true compare carries 0/1
    a_cmp_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[63] |->
            o_m_axis_tdata[31:0] == 32'd0 && o_m_axis_tdata[62:32] == 31'd1)
        else $error("bad compare result");

    // denominator is never zero
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[62:32] != 31'd0)
        else $error("zero denominator out");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

// ===== sim/tb.sv =====
// self-checking testbench for the rational arithmetic unit
module tb;

    localparam int unsigned OPW = 16;
    localparam int unsigned N_RANDOM = 1300;

    typedef struct packed {
        logic                             zero_den_error;
        logic                             cmp_true;
        logic [rau_pkg::DEN_W-1:0]        res_den;
        logic signed [rau_pkg::NUM_W-1:0] res_num;
    } t_frac_result;

    // sign extend an operand from its low OPW bits
    function automatic longint signed op_value(logic [rau_pkg::FLD_W-1:0] v);
        logic [OPW-1:0] t;
        t = v[OPW-1:0];
        return longint'($signed(t));
    endfunction

    function automatic longint unsigned abs_val(longint signed v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned binary_gcd(longint unsigned x, longint unsigned y);
        int k;
        longint unsigned t;
        k = 0;
        if (x == 0) return y;
        if (y == 0) return x;
        while (((x | y) & 1) == 0) begin
            x = x >> 1;
            y = y >> 1;
            k++;
        end
        while ((x & 1) == 0) x = x >> 1;
        while (y != 0) begin
            while ((y & 1) == 0) y = y >> 1;
            if (x > y) begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        return x << k;
    endfunction

    function automatic logic signed [rau_pkg::NUM_W-1:0] clamp_num(longint signed v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[rau_pkg::NUM_W-1:0];
    endfunction

    function automatic logic [rau_pkg::DEN_W-1:0] clamp_den(longint unsigned v);
        return v > 64'd2147483647 ? {rau_pkg::DEN_W{1'b1}} : v[rau_pkg::DEN_W-1:0];
    endfunction

    function automatic t_frac_result frac_compute(rau_pkg::t_cmd op,
            logic [rau_pkg::FLD_W-1:0] an_i, logic [rau_pkg::FLD_W-1:0] ad_i,
            logic [rau_pkg::FLD_W-1:0] bn_i, logic [rau_pkg::FLD_W-1:0] bd_i);
        t_frac_result r;
        longint signed an, ad, bn, bd, na, nb, n, t1, t2, lhs, rhs;
        longint unsigned da, db, g, d;
        r = '{zero_den_error: 1'b0, cmp_true: 1'b0, res_den: 1, res_num: 0};
        an = op_value(an_i);
        ad = op_value(ad_i);
        bn = op_value(bn_i);
        bd = op_value(bd_i);
        if (op > rau_pkg::CMD_GT) return r;
        if (ad == 0 || bd == 0) begin
            r.zero_den_error = 1'b1;
            return r;
        end
        na = ad < 0 ? -an : an;
        nb = bd < 0 ? -bn : bn;
        da = abs_val(ad);
        db = abs_val(bd);
        case (op)
            rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
                g = binary_gcd(da, db);
                t1 = na * longint'(db / g);
                t2 = nb * longint'(da / g);
                r.res_num = clamp_num(op == rau_pkg::CMD_ADD ? t1 + t2 : t1 - t2);
                r.res_den = clamp_den((da / g) * db);
            end
            rau_pkg::CMD_LT, rau_pkg::CMD_GT: begin
                lhs = na * longint'(db);
                rhs = nb * longint'(da);
                r.cmp_true = (op == rau_pkg::CMD_LT) ? (lhs < rhs) : (lhs > rhs);
            end
            default: begin
                if (op == rau_pkg::CMD_MUL) begin
                    n = na * nb;
                    d = da * db;
                end else begin
                    if (nb == 0) begin
                        r.zero_den_error = 1'b1;
                        return r;
                    end
                    n = na * longint'(db);
                    d = da * abs_val(nb);
                    if (nb < 0) n = -n;
                end
                g = binary_gcd(abs_val(n), d);
                r.res_num = clamp_num(n / longint'(g));
                r.res_den = clamp_den(d / g);
            end
        endcase
        return r;
    endfunction

    class frac_scoreboard;
        t_frac_result pending[$];
        bit failed;

        function void note_input(logic [rau_pkg::IN_TDATA_W-1:0] data);
            pending.push_back(frac_compute(data[2:0], data[18:3], data[34:19],
                                           data[50:35], data[66:51]));
        endfunction

        function void check_result(logic [rau_pkg::OUT_TDATA_W-1:0] data);
            t_frac_result want, got;
            got = data[64:0];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, data);
                failed = 1;
                return;
            end
            want = pending.pop_front();
            if (got.res_num !== want.res_num || got.res_den !== want.res_den ||
                    got.cmp_true !== want.cmp_true ||
                    got.zero_den_error !== want.zero_den_error) begin
                $display("%0t: mismatch expected num %0d den %0d cmp %b err %b,",
                         $time, want.res_num, want.res_den, want.cmp_true,
                         want.zero_den_error,
                         " got num %0d den %0d cmp %b err %b",
                         got.res_num, got.res_den, got.cmp_true, got.zero_den_error);
                failed = 1;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [rau_pkg::IN_TDATA_W-1:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [rau_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    frac_scoreboard fsb = new();
    bit quiet_phase = 1'b0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    always #1 i_clk = ~i_clk;

    rational_arithmetic_unit #(.OPERAND_WIDTH(OPW)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // pick an operand field, biased toward extremes and small values
    function automatic logic [rau_pkg::FLD_W-1:0] pick_field();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(8)) - 4);
            4, 5: return 16'(int'($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    // valid stays high after a transfer until the next idle or item decides it
    task automatic send_item(rau_pkg::t_cmd op, logic [rau_pkg::FLD_W-1:0] an,
                             logic [rau_pkg::FLD_W-1:0] ad, logic [rau_pkg::FLD_W-1:0] bn,
                             logic [rau_pkg::FLD_W-1:0] bd);
        while (!quiet_phase && $urandom_range(99) < 13) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tdata <= {5'b0, bd, bn, ad, an, op};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        fsb.note_input(i_s_axis_tdata);
        @(negedge i_clk);
    endtask

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) fsb.check_result(o_m_axis_tdata);
    end

    // receiver readiness
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= !hold_off && (quiet_phase || $urandom_range(99) >= 13);
        end
    end

    initial begin
        rau_pkg::t_cmd op;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int c = 0; c < 6; c++) begin
            send_item(rau_pkg::t_cmd'(c), 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
            send_item(rau_pkg::t_cmd'(c), 16'h8000, 16'h8000, 16'h8000, 16'hffff);
            send_item(rau_pkg::t_cmd'(c), 16'd3, 16'd0, 16'd1, 16'd2);
        end
        send_item(rau_pkg::CMD_DIV, 16'd5, 16'd7, 16'd0, 16'hfffd);
        send_item(rau_pkg::CMD_MUL, 16'd0, 16'd7, 16'd9, 16'd4);
        send_item(rau_pkg::CMD_LT, 16'd1, 16'd2, 16'd2, 16'd4);
        send_item(3'd6, 16'd1, 16'd2, 16'd3, 16'd4);
        send_item(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_item(rau_pkg::CMD_SUB, 16'hffff, 16'd6, 16'd1, 16'hfff7);
        // hold the receiver off while items keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int k = 0; k < 6; k++)
                send_item(rau_pkg::t_cmd'($urandom_range(5)), pick_field(), pick_field(),
                          pick_field(), pick_field());
        join
        for (int k = 0; k < N_RANDOM; k++) begin
            quiet_phase = (k >= 400 && k < 550);
            op = ($urandom_range(19) == 0) ? rau_pkg::t_cmd'($urandom_range(7, 6))
                                           : rau_pkg::t_cmd'($urandom_range(5));
            send_item(op, pick_field(), pick_field(), pick_field(), pick_field());
        end
        i_s_axis_tvalid <= 1'b0;
        quiet_phase = 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (fsb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (!fsb.failed) begin
            $display("rational_arithmetic_unit verification clean");
        end else begin
            $display("rational_arithmetic_unit verification failed");
        end
        $finish;
    end

    initial begin
        #10000000;
        $display("rational_arithmetic_unit verification failed");
        $finish;
    end

endmodule
